FILE: design/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// assert that a implies b on the same edge
`define CHK_IMPL(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("check failed");
// assert that a implies b on the next edge
`define CHK_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("check failed");
`endif

FILE: design/ffsa_pkg.sv
// types and codes of the first-fit segment allocator
`default_nettype none
package ffsa_pkg;
  localparam int unsigned ADDR_BITS = 20;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOFIT    = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  localparam logic [0:0] REG_REGION_SIZE = 1'd0;

  typedef struct packed {
    logic        cmd;
    logic [20:0] req_size;
    logic [20:0] req_align;
    logic [19:0] block_offset;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [19:0] grant_offset;
    logic [20:0] grant_size;
  } rsp_t;

  // divider handshake
  typedef struct packed {
    logic start;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;
endpackage
`default_nettype wire

FILE: design/ffsa_rem.sv
// bit-serial remainder unit, one quotient bit per cycle
`default_nettype none
module ffsa_rem #(
  parameter int unsigned NB = 21
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ffsa_pkg::div_ctl_t  ctl_i,
  input  logic [NB-1:0]       num_i,
  input  logic [NB-1:0]       den_i,
  output ffsa_pkg::div_sts_t  sts_o,
  output logic [NB-1:0]       rem_o
);
  import ffsa_pkg::*;
  localparam int unsigned CW = $clog2(NB + 1);

  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d, done_q, done_d;
  logic [NB-1:0] num_q, num_d, den_q, den_d;
  logic [NB:0]   rem_q, rem_d;
  logic [NB:0]   shifted;

  assign shifted = {rem_q[NB-1:0], num_q[NB-1]};

  always_comb begin
    cnt_d = cnt_q; busy_d = busy_q; done_d = 1'b0;
    num_d = num_q; den_d = den_q; rem_d = rem_q;
    if (ctl_i.start) begin
      busy_d = 1'b1; cnt_d = CW'(NB); num_d = num_i; den_d = den_i;
      rem_d = '0;
    end else if (busy_q) begin
      num_d = {num_q[NB-2:0], 1'b0};
      if (shifted >= {1'b0, den_q}) rem_d = shifted - {1'b0, den_q};
      else rem_d = shifted;
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0; busy_q <= 1'b0; done_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d; busy_q <= busy_d; done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d; den_q <= den_d; rem_q <= rem_d;
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign rem_o = rem_q[NB-1:0];
endmodule
`default_nettype wire

FILE: design/first_fit_segment_allocator.sv
// first-fit segment allocator, top level
// Requests arrive on req_valid_i/req_ready_o with a req_t payload (cmd, req_size,
// req_align, block_offset); each request gives one response on rsp_valid_o/rsp_ready_i.
// The block handles one request at a time: ready is low from acceptance until the
// response register is free again.
// A free walks the segment table one entry at a time, each through a registered memory
// read (S_RD, then S_CHK); a match goes through S_FWB and S_RSP to a valid response.
// An allocate walks the table the same way; for each free candidate the remainder unit
// computes its start modulo the alignment (S_DIVW), S_FIT tests the fit, and a split
// (S_SPLIT, if the segment is larger) and write-back (S_WB) follow before S_RSP.
// The response waits in its output register while the receiver stalls; a new
// request is taken only after that response is gone.
// After reset the table holds one free segment of 65536 bytes; entry 0 is written in
// the first cycle after reset, and ready stays low in that cycle. Writing region_size
// over the APB port in S_IDLE resets the table to one free segment of the new size;
// the table memory needs no clearing since entries past seg_count are never read.
`default_nettype none
module first_fit_segment_allocator #(
  parameter int unsigned MAX_SEGMENTS = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                req_valid_i,
  output logic                req_ready_o,
  input  ffsa_pkg::req_t      req_i,
  output logic                rsp_valid_o,
  input  logic                rsp_ready_i,
  output ffsa_pkg::rsp_t      rsp_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [1:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import ffsa_pkg::*;
  localparam int unsigned IW = $clog2(MAX_SEGMENTS);
  localparam int unsigned CW = $clog2(MAX_SEGMENTS + 1);
  localparam int unsigned SW = 21;
  localparam int unsigned OW = 20;
  localparam logic [SW:0] RMAX = (SW+1)'(64'd1 << ADDR_BITS);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RD    = 4'd1;
  localparam logic [3:0] S_CHK   = 4'd2;
  localparam logic [3:0] S_DIVW  = 4'd3;
  localparam logic [3:0] S_FIT   = 4'd4;
  localparam logic [3:0] S_SPLIT = 4'd5;
  localparam logic [3:0] S_WB    = 4'd6;
  localparam logic [3:0] S_FWB   = 4'd7;
  localparam logic [3:0] S_RSP   = 4'd8;

  logic [3:0]    state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [IW-1:0] idx_q, idx_d;
  logic [SW-1:0] region_q, region_d;
  req_t          req_q, req_d;
  rsp_t          rsp_q, rsp_d;
  logic          rsp_vq, rsp_vd;
  logic [SW-1:0] avail_q, avail_d;
  logic [SW-1:0] start_q, start_d;
  logic          init_q;

  logic [OW-1:0] st_mem [MAX_SEGMENTS];
  logic [SW-1:0] ln_mem [MAX_SEGMENTS];
  logic          fr_mem [MAX_SEGMENTS];
  logic [OW-1:0] st_rd;
  logic [SW-1:0] ln_rd;
  logic          fr_rd;

  logic          we;
  logic [IW-1:0] wa;
  logic [OW-1:0] wst;
  logic [SW-1:0] wln;
  logic          wfr;

  div_ctl_t      dctl;
  div_sts_t      dsts;
  logic [SW-1:0] rem;
  logic [SW-1:0] align_eff;
  logic [SW:0]   pad;
  logic          cfg_wr;
  logic [SW-1:0] cfg_v;

  assign align_eff = (req_q.req_align == '0) ? SW'(1) : req_q.req_align;
  assign pad = (rem == '0) ? '0 : ({1'b0, align_eff} - {1'b0, rem});

  ffsa_rem #(.NB(SW)) u_rem (
    .clk_i, .rst_ni, .ctl_i(dctl),
    .num_i(SW'(st_rd)), .den_i(align_eff),
    .sts_o(dsts), .rem_o(rem)
  );

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[1:1] == REG_REGION_SIZE);
  always_comb begin
    cfg_v = pwdata[SW-1:0];
    if (cfg_v == '0) cfg_v = SW'(1);
    if ({1'b0, cfg_v} > RMAX) cfg_v = RMAX[SW-1:0];
  end
  assign prdata = (paddr[1:1] == REG_REGION_SIZE) ? {11'd0, region_q} : '0;

  always_ff @(posedge clk_i) begin
    if (we) begin
      st_mem[wa] <= wst; ln_mem[wa] <= wln; fr_mem[wa] <= wfr;
    end
    st_rd <= st_mem[idx_q]; ln_rd <= ln_mem[idx_q]; fr_rd <= fr_mem[idx_q];
  end

  always_comb begin
    state_d = state_q; cnt_d = cnt_q; idx_d = idx_q; region_d = region_q;
    req_d = req_q; rsp_d = rsp_q; rsp_vd = rsp_vq;
    avail_d = avail_q; start_d = start_q;
    we = 1'b0; wa = idx_q; wst = st_rd; wln = ln_rd; wfr = fr_rd;
    dctl.start = 1'b0;
    // seed entry 0 with the reset region in the first cycle after reset
    if (init_q) begin
      we = 1'b1; wa = '0; wst = '0; wln = region_q; wfr = 1'b1;
    end
    if (rsp_vq && rsp_ready_i) rsp_vd = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (cfg_wr) begin
          region_d = cfg_v; cnt_d = CW'(1);
          we = 1'b1; wa = '0; wst = '0; wln = cfg_v; wfr = 1'b1;
        end else if (req_valid_i && req_ready_o) begin
          req_d = req_i; idx_d = '0;
          if (req_i.cmd == CMD_ALLOC &&
              (req_i.req_size == '0 || req_i.req_size > region_q)) begin
            rsp_d = '{ST_NOFIT, '0, '0}; state_d = S_RSP;
          end else begin
            state_d = S_RD;
          end
        end
      end
      S_RD: state_d = S_CHK;
      S_CHK: begin
        if (req_q.cmd == CMD_FREE) begin
          if (st_rd == req_q.block_offset && ln_rd == req_q.req_size) begin
            state_d = S_FWB;
          end
        end else if (fr_rd) begin
          dctl.start = 1'b1; state_d = S_DIVW;
        end
        if (state_d == S_CHK) begin
          if ({1'b0, idx_q} + (IW+1)'(1) >= (IW+1)'(cnt_q)) begin
            rsp_d = '{(req_q.cmd == CMD_FREE) ? ST_NOTFOUND : ST_NOFIT, '0, '0};
            state_d = S_RSP;
          end else begin
            idx_d = idx_q + IW'(1); state_d = S_RD;
          end
        end
      end
      S_DIVW: if (dsts.done) state_d = S_FIT;
      S_FIT: begin
        if (pad <= {1'b0, ln_rd} && (ln_rd - pad[SW-1:0]) >= req_q.req_size) begin
          avail_d = ln_rd - pad[SW-1:0];
          start_d = SW'(st_rd) + pad[SW-1:0];
          if (avail_d > req_q.req_size) begin
            if (cnt_q >= CW'(MAX_SEGMENTS)) begin
              rsp_d = '{ST_FULL, '0, '0}; state_d = S_RSP;
            end else state_d = S_SPLIT;
          end else state_d = S_WB;
        end else if ({1'b0, idx_q} + (IW+1)'(1) >= (IW+1)'(cnt_q)) begin
          rsp_d = '{ST_NOFIT, '0, '0}; state_d = S_RSP;
        end else begin
          idx_d = idx_q + IW'(1); state_d = S_RD;
        end
      end
      S_SPLIT: begin
        we = 1'b1; wa = cnt_q[IW-1:0];
        wst = OW'(start_q + req_q.req_size);
        wln = avail_q - req_q.req_size; wfr = 1'b1;
        cnt_d = cnt_q + CW'(1); state_d = S_WB;
      end
      S_WB: begin
        we = 1'b1; wst = start_q[OW-1:0]; wln = req_q.req_size; wfr = 1'b0;
        rsp_d = '{ST_OK, start_q[OW-1:0], req_q.req_size}; state_d = S_RSP;
      end
      S_FWB: begin
        we = 1'b1; wfr = 1'b1;
        rsp_d = '{ST_OK, '0, '0}; state_d = S_RSP;
      end
      S_RSP: begin
        rsp_vd = 1'b1; state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; cnt_q <= CW'(1); idx_q <= '0;
      region_q <= SW'(65536); rsp_vq <= 1'b0;
    end else begin
      state_q <= state_d; cnt_q <= cnt_d; idx_q <= idx_d;
      region_q <= region_d; rsp_vq <= rsp_vd;
    end
  end

  // entry 0 after reset is written by a one-time init flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) init_q <= 1'b1;
    else init_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d; rsp_q <= rsp_d; avail_q <= avail_d; start_q <= start_d;
  end

  assign req_ready_o = (state_q == S_IDLE) && !rsp_vq && !cfg_wr && !init_q;
  assign rsp_valid_o = rsp_vq;
  assign rsp_o = rsp_q;
endmodule
`default_nettype wire

FILE: design/ffsa_checker.sv
// port-level checks of the allocator, bound to the top level
`default_nettype none
`include "assert_macros.svh"
module ffsa_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           req_valid_i,
  input logic           req_ready_o,
  input logic           rsp_valid_o,
  input logic           rsp_ready_i,
  input ffsa_pkg::rsp_t rsp_o
);
  import ffsa_pkg::*;
  `CHK_IMPL(a_no_ready_while_rsp, clk_i, rst_ni, rsp_valid_o, !req_ready_o)
  `CHK_NEXT(a_rsp_holds, clk_i, rst_ni, rsp_valid_o && !rsp_ready_i,
            rsp_valid_o && $stable(rsp_o))
  `CHK_IMPL(a_err_zero, clk_i, rst_ni, rsp_valid_o && rsp_o.status != ST_OK,
            rsp_o.grant_size == '0 && rsp_o.grant_offset == '0)
  `CHK_NEXT(a_busy_after_req, clk_i, rst_ni, req_valid_i && req_ready_o, !req_ready_o)
endmodule
bind first_fit_segment_allocator ffsa_checker u_chk (
  .clk_i, .rst_ni, .req_valid_i, .req_ready_o, .rsp_valid_o, .rsp_ready_i, .rsp_o
);
`default_nettype wire

FILE: test/first_fit_segment_allocator_tb.sv
// testbench of the first-fit segment allocator: directed table, random traffic, scoreboard
`default_nettype none
module first_fit_segment_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ffsa_pkg::*;

  localparam int NSEG = 64;
  localparam logic [21:0] REGION_CAP = 22'd1048576;
  localparam int IDLE_LIMIT = 200000;

  logic clk_i, rst_ni;
  logic req_valid_i, req_ready_o, rsp_valid_o, rsp_ready_i;
  req_t req_i;
  rsp_t rsp_o;
  logic psel, penable, pwrite, pready;
  logic [1:0] paddr;
  logic [31:0] pwdata, prdata;

  first_fit_segment_allocator DUT (.*);

  // allocator state mirror
  logic [19:0] blk_start [NSEG];
  logic [20:0] blk_len [NSEG];
  logic        blk_free [NSEG];
  int          blk_count;
  logic [20:0] region_bytes;

  rsp_t pending_rsp [$];
  // granted blocks, kept to build valid frees
  logic [40:0] granted [$];
  int errors = 0, idle_cycles = 0;
  logic rx_hold = 0;

  function automatic void table_reset(logic [20:0] sz);
    region_bytes = sz;
    for (int k = 0; k < NSEG; k++) begin
      blk_start[k] = '0; blk_len[k] = '0; blk_free[k] = 1'b0;
    end
    blk_len[0] = sz; blk_free[0] = 1'b1; blk_count = 1;
  endfunction

  function automatic rsp_t predict_grant(req_t r);
    rsp_t o;
    logic [21:0] al, rem, pad, avail, st;
    o = '0;
    if (r.cmd == CMD_FREE) begin
      for (int k = 0; k < blk_count; k++)
        if (blk_start[k] == r.block_offset && blk_len[k] == r.req_size) begin
          blk_free[k] = 1'b1;
          return o;
        end
      o.status = ST_NOTFOUND;
      return o;
    end
    al = (r.req_align == 0) ? 22'd1 : {1'b0, r.req_align};
    o.status = ST_NOFIT;
    if (r.req_size == 0 || r.req_size > region_bytes) return o;
    for (int k = 0; k < blk_count; k++) begin
      if (!blk_free[k]) continue;
      rem = blk_start[k] % al;
      pad = (rem == 0) ? 22'd0 : al - rem;
      if (pad > blk_len[k]) continue;
      avail = blk_len[k] - pad;
      if (avail < r.req_size) continue;
      st = blk_start[k] + pad;
      if (avail > r.req_size) begin
        if (blk_count >= NSEG) begin
          o.status = ST_FULL;
          return o;
        end
        blk_start[blk_count] = 20'(st + r.req_size);
        blk_len[blk_count] = 21'(avail - r.req_size);
        blk_free[blk_count] = 1'b1;
        blk_count++;
      end
      blk_start[k] = st[19:0]; blk_len[k] = r.req_size; blk_free[k] = 1'b0;
      o.status = ST_OK; o.grant_offset = st[19:0]; o.grant_size = r.req_size;
      granted.insert(granted.size(), {st[19:0], r.req_size});
      return o;
    end
    return o;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  initial begin
    clk_i = 0;
    forever #4 clk_i = ~clk_i;
  end

  // response side: random stalls, one long hold-off on request
  initial begin
    rsp_ready_i = 0;
    forever begin
      @(posedge clk_i);
      if (rx_hold) rsp_ready_i <= 1'b0;
      else if ($urandom_range(0, 9) < 7) rsp_ready_i <= 1'b1;
      else if ($urandom_range(0, 19) == 0) begin
        rsp_ready_i <= 1'b0;
        repeat ($urandom_range(10, 60)) @(posedge clk_i);
      end else rsp_ready_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && rsp_valid_o && rsp_ready_i) begin
      if (pending_rsp.size() == 0) begin
        report_mismatch("unexpected response", 32'd0, 32'd0);
      end else begin
        rsp_t w;
        w = pending_rsp.pop_front();
        if (rsp_o.status != w.status)
          report_mismatch("status", 32'(rsp_o.status), 32'(w.status));
        if (rsp_o.grant_offset != w.grant_offset)
          report_mismatch("grant_offset", 32'(rsp_o.grant_offset), 32'(w.grant_offset));
        if (rsp_o.grant_size != w.grant_size)
          report_mismatch("grant_size", 32'(rsp_o.grant_size), 32'(w.grant_size));
      end
    end
  end

  // watchdog on acceptance activity
  always @(posedge clk_i) begin
    if ((req_valid_i && req_ready_o) || (rsp_valid_o && rsp_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // valid stays high into the next request unless a gap is taken
  task automatic send_request(req_t r, bit chk, rsp_t want);
    rsp_t p;
    if ($urandom_range(0, 3) == 0) begin
      req_valid_i <= 1'b0;
      repeat ($urandom_range(0, 9) == 0 ? $urandom_range(20, 80) : $urandom_range(1, 3))
        @(posedge clk_i);
    end
    req_valid_i <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (!req_ready_o);
    p = predict_grant(r);
    if (chk && p != want) begin
      $display("directed row disagrees with prediction");
      errors++;
    end
    pending_rsp.insert(pending_rsp.size(), p);
  endtask

  task automatic wait_drained();
    req_valid_i <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk_i);
    repeat (3000) @(posedge clk_i);
  endtask

  task automatic write_region(logic [31:0] v);
    logic [21:0] s;
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {REG_REGION_SIZE, 1'b0}; pwdata <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    s = {1'b0, v[20:0]};
    if (s == 0) s = 1;
    if (s > REGION_CAP) s = REGION_CAP;
    table_reset(s[20:0]);
    granted.delete();
  endtask

  function automatic req_t mk(logic c, int sz, int al, int off);
    req_t r;
    r.cmd = c; r.req_size = 21'(sz); r.req_align = 21'(al); r.block_offset = 20'(off);
    return r;
  endfunction

  function automatic rsp_t rs(logic [1:0] s, int off, int sz);
    rsp_t o;
    o.status = s; o.grant_offset = 20'(off); o.grant_size = 21'(sz);
    return o;
  endfunction

  typedef struct {
    req_t r;
    bit   chk;
    rsp_t want;
  } dir_row_t;

  dir_row_t dir_rows [$];

  function automatic void add_row(req_t r, bit chk, rsp_t want);
    dir_row_t row;
    row.r = r; row.chk = chk; row.want = want;
    dir_rows.insert(dir_rows.size(), row);
  endfunction

  task automatic random_phase(int n, int maxsz);
    req_t r;
    logic [40:0] g;
    for (int k = 0; k < n; k++) begin
      r = mk(CMD_ALLOC, 0, 0, 0);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          r.req_size = 21'($urandom_range(1, maxsz));
          r.req_align = 21'(1 << $urandom_range(0, 12));
        end
        4, 5, 6: if (granted.size() != 0) begin
          g = granted[$urandom_range(0, granted.size() - 1)];
          r.cmd = CMD_FREE; r.block_offset = g[40:21]; r.req_size = g[20:0];
          r.req_align = 21'($urandom);
        end
        7: begin
          r.cmd = CMD_FREE; r.req_size = 21'($urandom); r.block_offset = 20'($urandom);
          r.req_align = 21'($urandom);
        end
        default: begin
          r.req_size = 21'($urandom); r.req_align = 21'($urandom);
          r.block_offset = 20'($urandom);
        end
      endcase
      if (r.cmd == CMD_ALLOC) r.block_offset = 20'($urandom);
      send_request(r, 0, '0);
    end
  endtask

  initial begin
    req_valid_i = 0; req_i = '0;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    rst_ni = 0;
    table_reset(21'd65536);
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    add_row(mk(CMD_ALLOC, 0, 1, 0), 1, rs(ST_NOFIT, 0, 0));
    add_row(mk(CMD_ALLOC, 65537, 1, 0), 1, rs(ST_NOFIT, 0, 0));
    add_row(mk(CMD_ALLOC, 21'h1FFFFF, 21'h1FFFFF, 20'hFFFFF), 1, rs(ST_NOFIT, 0, 0));
    add_row(mk(CMD_ALLOC, 100, 0, 20'hFFFFF), 1, rs(ST_OK, 0, 100));
    add_row(mk(CMD_ALLOC, 16, 64, 0), 1, rs(ST_OK, 128, 16));
    add_row(mk(CMD_ALLOC, 1, 21'h100000, 0), 1, rs(ST_NOFIT, 0, 0));
    add_row(mk(CMD_FREE, 100, 0, 0), 1, rs(ST_OK, 0, 0));
    add_row(mk(CMD_FREE, 100, 0, 0), 1, rs(ST_OK, 0, 0));
    add_row(mk(CMD_FREE, 7, 0, 5), 1, rs(ST_NOTFOUND, 0, 0));
    add_row(mk(CMD_FREE, 21'h1FFFFF, 21'h1FFFFF, 20'hFFFFF), 1, rs(ST_NOTFOUND, 0, 0));
    add_row(mk(CMD_ALLOC, 100, 1, 0), 0, '0);
    add_row(mk(CMD_ALLOC, 28, 4, 0), 0, '0);
    add_row(mk(CMD_ALLOC, 65000, 2, 0), 0, '0);
    foreach (dir_rows[k]) send_request(dir_rows[k].r, dir_rows[k].chk, dir_rows[k].want);
    wait_drained();

    // table full: small grants, each split until the table has no room and ST_FULL comes back
    write_region(32'd4096);
    for (int k = 0; k < 66; k++) send_request(mk(CMD_ALLOC, 8, 1, 0), 0, '0);
    send_request(mk(CMD_ALLOC, 4096, 1, 0), 1, rs(ST_NOFIT, 0, 0));
    wait_drained();

    write_region(32'd0);
    send_request(mk(CMD_ALLOC, 1, 0, 0), 1, rs(ST_OK, 0, 1));
    send_request(mk(CMD_ALLOC, 2, 1, 0), 1, rs(ST_NOFIT, 0, 0));
    wait_drained();

    write_region(32'hFFFF_FFFF);
    send_request(mk(CMD_ALLOC, 21'h100000, 1, 0), 1, rs(ST_OK, 0, 21'h100000));
    send_request(mk(CMD_ALLOC, 21'h100001, 1, 0), 1, rs(ST_NOFIT, 0, 0));
    wait_drained();

    write_region(32'd1048576);
    random_phase(300, 2048);
    // long receiver hold-off so the response register stays full and the block stalls its input
    fork
      begin
        rx_hold = 1;
        repeat (400) @(posedge clk_i);
        rx_hold = 0;
      end
      random_phase(40, 512);
    join
    wait_drained();

    write_region(32'd8192);
    random_phase(400, 512);
    wait_drained();

    write_region(32'd65536);
    random_phase(330, 4096);

    wait_drained();
    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end
endmodule
`default_nettype wire

FILE: files.f
+incdir+design
design/ffsa_pkg.sv
design/ffsa_rem.sv
design/first_fit_segment_allocator.sv
design/ffsa_checker.sv
test/first_fit_segment_allocator_tb.sv
